// ===== rtl/euler_to_quaternion_core_defines.svh =====
// Assertion macros shared by the Euler-to-quaternion RTL.
`ifndef EULER_TO_QUATERNION_CORE_DEFINES_SVH
`define EULER_TO_QUATERNION_CORE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define ETQ_ASSERT_IMP(lbl, ck, rn, ante, cons) \
lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
else $error("etq check failed");

// Next-cycle implication, checked while out of reset.
`define ETQ_ASSERT_NXT(lbl, ck, rn, ante, cons) \
lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
else $error("etq check failed");

`endif

// ===== rtl/etq_pkg.sv =====
// Shared constants, stage counts and the sine table generator.
`timescale 1ns / 1ps
`default_nettype none
package etq_pkg;

	localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
	localparam logic signed [24:0] HALF_PI_Q17 = 25'sd205887;
	localparam logic [31:0] LEN_EPS_Q28 = 32'd2684;
	localparam logic [14:0] ONE_Q14 = 15'd16384;

	localparam int ANG_STAGES = 3;
	localparam int QMUL_STAGES = 6;
	localparam int SQRT_STAGES = 32;
	localparam int DIV_STAGES = 16;
	localparam int NUM_STAGES = ANG_STAGES + QMUL_STAGES + SQRT_STAGES + DIV_STAGES;

	localparam longint TWO_PI_Q30 = 64'sd6746518852;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint SIN_DEN [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

	typedef logic [3:0][31:0] quat_vec_t;

	// Sine table entry i of a table with 2**lg entries, Q1.14.
	function automatic logic signed [15:0] sine_entry(input longint i, input int lg);
		longint size;
		longint a;
		longint x;
		longint ax;
		longint x2;
		longint term;
		longint sum;
		longint v;
		int k;
		size = longint'(1) << lg;
		if (4 * i <= size) begin
			a = i;
		end else if (4 * i < 3 * size) begin
			a = (size >>> 1) - i;
		end else begin
			a = i - size;
		end
		if (a >= 0) begin
			x = (a * TWO_PI_Q30) >>> lg;
		end else begin
			x = -(((-a) * TWO_PI_Q30) >>> lg);
		end
		ax = (x < 0) ? -x : x;
		x2 = (ax * ax) >>> 30;
		term = x;
		sum = x;
		for (k = 0; k < 8; k++) begin
			term = term * x2 / ONE_Q30;
			term = -term / SIN_DEN[k];
			sum += term;
		end
		if (sum >= 0) begin
			v = (sum + 32768) >>> 16;
		end else begin
			v = -((-sum + 32768) >>> 16);
		end
		return 16'(v);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/etq_angle.sv =====
// Angle to table index and sine ROM lookup for one angle, three stages.
`timescale 1ns / 1ps
`default_nettype none
module etq_angle #(
	parameter int TABLE_SIZE = 1024
) (
	input  wire logic               clk,
	input  wire logic [2:0]         en,
	input  wire logic signed [23:0] angle,
	output logic signed [15:0]      sin_val,
	output logic signed [15:0]      cos_val
);

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int SHIFT = 49 - IDX_W;

	typedef logic signed [15:0] rom_t [TABLE_SIZE];

	function automatic rom_t build_rom();
		rom_t r;
		int i;
		for (i = 0; i < TABLE_SIZE; i++) begin
			r[i] = etq_pkg::sine_entry(longint'(i), IDX_W);
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic signed [24:0] sin_arg, cos_arg;
	logic [24:0] sin_mag, cos_mag;
	logic [54:0] sin_prod, cos_prod;
	logic [54:0] sin_p_s1, cos_p_s1;
	logic sin_neg_s1, cos_neg_s1;
	logic [IDX_W-1:0] sin_n, cos_n;
	logic [IDX_W-1:0] sin_idx_s2, cos_idx_s2;
	logic signed [15:0] sin_s3, cos_s3;

	always_comb begin
		sin_arg = {angle[23], angle};
		cos_arg = sin_arg + etq_pkg::HALF_PI_Q17;
		sin_mag = sin_arg[24] ? 25'(-sin_arg) : 25'(sin_arg);
		cos_mag = cos_arg[24] ? 25'(-cos_arg) : 25'(cos_arg);
		sin_prod = sin_mag * etq_pkg::INV_TWO_PI_Q32;
		cos_prod = cos_mag * etq_pkg::INV_TWO_PI_Q32;
		sin_n = sin_p_s1[SHIFT +: IDX_W];
		cos_n = cos_p_s1[SHIFT +: IDX_W];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sin_p_s1 <= sin_prod;
			cos_p_s1 <= cos_prod;
			sin_neg_s1 <= sin_arg[24];
			cos_neg_s1 <= cos_arg[24];
		end
		if (en[1]) begin
			sin_idx_s2 <= sin_neg_s1 ? (~sin_n + 1'b1) : sin_n;
			cos_idx_s2 <= cos_neg_s1 ? (~cos_n + 1'b1) : cos_n;
		end
		if (en[2]) begin
			sin_s3 <= SINE_ROM[sin_idx_s2];
			cos_s3 <= SINE_ROM[cos_idx_s2];
		end
	end

	assign sin_val = sin_s3;
	assign cos_val = cos_s3;

endmodule
`default_nettype wire

// ===== rtl/etq_qmul.sv =====
// Quaternion products, rounding to Q.28 and the sum of squares, six stages.
`timescale 1ns / 1ps
`default_nettype none
module etq_qmul (
	input  wire logic               clk,
	input  wire logic [5:0]         en,
	input  wire logic signed [15:0] sp,
	input  wire logic signed [15:0] cp,
	input  wire logic signed [15:0] sy,
	input  wire logic signed [15:0] cy,
	input  wire logic signed [15:0] sr,
	input  wire logic signed [15:0] cr,
	output etq_pkg::quat_vec_t      qc,
	output logic [61:0]             ss
);

	logic signed [29:0] tx_s4, ty_s4, tz_s4, tw_s4;
	logic signed [15:0] sr_s4, cr_s4;
	logic signed [44:0] xc_s5, ys_s5, yc_s5, xs_s5, ws_s5, zc_s5, wc_s5, zs_s5;
	logic signed [45:0] vx, vy, vz, vw;
	logic signed [31:0] qx_s6, qy_s6, qz_s6, qw_s6;
	logic signed [63:0] sqx, sqy, sqz, sqw;
	logic [59:0] sqx_s7, sqy_s7, sqz_s7, sqw_s7;
	logic [60:0] sxy_s8, szw_s8;
	logic [61:0] ss_s9;
	etq_pkg::quat_vec_t qc_s7, qc_s8, qc_s9;

	always_comb begin
		vx = 46'(xc_s5) + 46'(ys_s5) + 46'sd8192;
		vy = 46'(yc_s5) - 46'(xs_s5) + 46'sd8192;
		vz = 46'(ws_s5) + 46'(zc_s5) + 46'sd8192;
		vw = 46'(wc_s5) - 46'(zs_s5) + 46'sd8192;
		sqx = qx_s6 * qx_s6;
		sqy = qy_s6 * qy_s6;
		sqz = qz_s6 * qz_s6;
		sqw = qw_s6 * qw_s6;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			tx_s4 <= cy * sp;
			ty_s4 <= sy * cp;
			tz_s4 <= -(sy * sp);
			tw_s4 <= cy * cp;
			sr_s4 <= sr;
			cr_s4 <= cr;
		end
		if (en[1]) begin
			xc_s5 <= tx_s4 * cr_s4;
			ys_s5 <= ty_s4 * sr_s4;
			yc_s5 <= ty_s4 * cr_s4;
			xs_s5 <= tx_s4 * sr_s4;
			ws_s5 <= tw_s4 * sr_s4;
			zc_s5 <= tz_s4 * cr_s4;
			wc_s5 <= tw_s4 * cr_s4;
			zs_s5 <= tz_s4 * sr_s4;
		end
		if (en[2]) begin
			qx_s6 <= vx[45:14];
			qy_s6 <= vy[45:14];
			qz_s6 <= vz[45:14];
			qw_s6 <= vw[45:14];
		end
		if (en[3]) begin
			sqx_s7 <= sqx[59:0];
			sqy_s7 <= sqy[59:0];
			sqz_s7 <= sqz[59:0];
			sqw_s7 <= sqw[59:0];
			qc_s7 <= {qw_s6, qz_s6, qy_s6, qx_s6};
		end
		if (en[4]) begin
			sxy_s8 <= 61'(sqx_s7) + 61'(sqy_s7);
			szw_s8 <= 61'(sqz_s7) + 61'(sqw_s7);
			qc_s8 <= qc_s7;
		end
		if (en[5]) begin
			ss_s9 <= 62'(sxy_s8) + 62'(szw_s8);
			qc_s9 <= qc_s8;
		end
	end

	assign qc = qc_s9;
	assign ss = ss_s9;

endmodule
`default_nettype wire

// ===== rtl/etq_sqrt.sv =====
// Integer square root, one result bit per pipeline stage.
`timescale 1ns / 1ps
`default_nettype none
module etq_sqrt (
	input  wire logic                                clk,
	input  wire logic [etq_pkg::SQRT_STAGES-1:0]     en,
	input  wire logic [61:0]                         ss,
	input  wire etq_pkg::quat_vec_t                  qc_in,
	output logic [31:0]                              len,
	output etq_pkg::quat_vec_t                       qc_out
);

	localparam int N = etq_pkg::SQRT_STAGES;

	logic [63:0] rem_s [N];
	logic [63:0] res_s [N];
	etq_pkg::quat_vec_t qc_s [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] rem_in, res_in, trial;
		etq_pkg::quat_vec_t qc_prev;

		if (k == 0) begin : g_first
			assign rem_in = {2'b00, ss};
			assign res_in = '0;
			assign qc_prev = qc_in;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign res_in = res_s[k-1];
			assign qc_prev = qc_s[k-1];
		end

		assign trial = res_in + BIT;

		always_ff @(posedge clk) begin
			if (en[k]) begin
				if (rem_in >= trial) begin
					rem_s[k] <= rem_in - trial;
					res_s[k] <= (res_in >> 1) + BIT;
				end else begin
					rem_s[k] <= rem_in;
					res_s[k] <= res_in >> 1;
				end
				qc_s[k] <= qc_prev;
			end
		end
	end

	assign len = res_s[N-1][31:0];
	assign qc_out = qc_s[N-1];

endmodule
`default_nettype wire

// ===== rtl/etq_div.sv =====
// Restoring division of each component by the length, then rounding and clamping.
`timescale 1ns / 1ps
`default_nettype none
module etq_div (
	input  wire logic                            clk,
	input  wire logic [etq_pkg::DIV_STAGES-1:0]  en,
	input  wire logic [31:0]                     len,
	input  wire etq_pkg::quat_vec_t              qc,
	output logic [3:0][15:0]                     quat
);

	localparam int STEPS = etq_pkg::DIV_STAGES - 1;

	logic [31:0] len_s [STEPS];
	logic tiny_s [STEPS];
	logic [3:0] neg_s [STEPS];
	logic [3:0][13:0] nlo_s [STEPS];
	logic [3:0][31:0] rem_s [STEPS];
	logic [3:0][14:0] quo_s [STEPS];
	logic [3:0][15:0] quat_s16;

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		logic [3:0][31:0] rem_in;
		logic [3:0] nbit;
		logic [3:0][32:0] t;
		logic [3:0][31:0] rem_nx;
		logic [3:0] qbit;
		logic [31:0] len_in;
		logic tiny_in;
		logic [3:0] neg_in;
		logic [3:0][13:0] nlo_in;
		logic [3:0][14:0] quo_in;

		if (j == 0) begin : g_first
			logic [3:0][31:0] mag;
			logic [3:0][46:0] num;
			always_comb begin
				for (int c = 0; c < 4; c++) begin
					mag[c] = qc[c][31] ? (~qc[c] + 32'd1) : qc[c];
					num[c] = 47'({mag[c], 14'd0}) + 47'(len[31:1]);
					rem_in[c] = num[c][46:15];
					nbit[c] = num[c][14];
					nlo_in[c] = num[c][13:0];
					neg_in[c] = qc[c][31];
				end
			end
			assign len_in = len;
			assign tiny_in = (len <= etq_pkg::LEN_EPS_Q28);
			assign quo_in = '0;
		end else begin : g_next
			always_comb begin
				for (int c = 0; c < 4; c++) begin
					rem_in[c] = rem_s[j-1][c];
					nbit[c] = nlo_s[j-1][c][14-j];
				end
			end
			assign len_in = len_s[j-1];
			assign tiny_in = tiny_s[j-1];
			assign neg_in = neg_s[j-1];
			assign nlo_in = nlo_s[j-1];
			assign quo_in = quo_s[j-1];
		end

		always_comb begin
			for (int c = 0; c < 4; c++) begin
				t[c] = {rem_in[c], nbit[c]};
				qbit[c] = (t[c] >= {1'b0, len_in});
				rem_nx[c] = qbit[c] ? 32'(t[c] - {1'b0, len_in}) : t[c][31:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				len_s[j] <= len_in;
				tiny_s[j] <= tiny_in;
				neg_s[j] <= neg_in;
				nlo_s[j] <= nlo_in;
				rem_s[j] <= rem_nx;
				for (int c = 0; c < 4; c++) begin
					quo_s[j][c] <= quo_in[c] | (15'(qbit[c]) << (14 - j));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[STEPS]) begin
			for (int c = 0; c < 4; c++) begin
				if (tiny_s[STEPS-1]) begin
					quat_s16[c] <= (c == 3) ? 16'(etq_pkg::ONE_Q14) : 16'd0;
				end else if (quo_s[STEPS-1][c] > etq_pkg::ONE_Q14) begin
					quat_s16[c] <= neg_s[STEPS-1][c] ? 16'(-16'sd16384) : 16'(etq_pkg::ONE_Q14);
				end else begin
					quat_s16[c] <= neg_s[STEPS-1][c] ? (~{1'b0, quo_s[STEPS-1][c]} + 16'd1)
						: {1'b0, quo_s[STEPS-1][c]};
				end
			end
		end
	end

	assign quat = quat_s16;

endmodule
`default_nettype wire

// ===== rtl/euler_to_quaternion_core.sv =====
// Top level: Euler angles (Y, X, Z order) to a normalized unit quaternion.
`timescale 1ns / 1ps
`default_nettype none
// Converts pitch, yaw and roll angles in Q6.17 radians into a unit quaternion in Q1.14,
// or the identity when the quaternion length is too small. The datapath is a 57-stage
// pipeline: three stages of index math and sine lookup, six of quaternion products and
// sum of squares, 32 of square root (one root bit per stage) and 16 of division and
// output rounding. A request is taken every cycle while the output side does not stall;
// an output stall holds only the full stages that have no empty stage after them.
`include "euler_to_quaternion_core_defines.svh"
module euler_to_quaternion_core #(
	parameter int TABLE_SIZE = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,  // pitch_angle, yaw_angle, roll_angle
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata   // quat_x, quat_y, quat_z, quat_w
);

	localparam int NS = etq_pkg::NUM_STAGES;
	localparam int QM0 = etq_pkg::ANG_STAGES;
	localparam int SQ0 = QM0 + etq_pkg::QMUL_STAGES;
	localparam int DV0 = SQ0 + etq_pkg::SQRT_STAGES;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;
	logic signed [15:0] sp, cp, sy, cy, sr, cr;
	etq_pkg::quat_vec_t qc_mul, qc_root;
	logic [61:0] ss;
	logic [31:0] len;
	logic [3:0][15:0] quat;

	for (genvar k = 0; k < NS; k++) begin : g_ctl
		assign en[k] = m_tready || !(&vld_q[NS-1:k]);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en[k]) begin
				vld_q[k] <= (k == 0) ? s_tvalid : vld_q[(k == 0) ? 0 : k - 1];
			end
		end
	end

	assign s_tready = en[0];

	etq_angle #(.TABLE_SIZE(TABLE_SIZE)) u_pitch (
		.clk(clk), .en(en[2:0]), .angle(s_tdata[23:0]), .sin_val(sp), .cos_val(cp)
	);
	etq_angle #(.TABLE_SIZE(TABLE_SIZE)) u_yaw (
		.clk(clk), .en(en[2:0]), .angle(s_tdata[47:24]), .sin_val(sy), .cos_val(cy)
	);
	etq_angle #(.TABLE_SIZE(TABLE_SIZE)) u_roll (
		.clk(clk), .en(en[2:0]), .angle(s_tdata[71:48]), .sin_val(sr), .cos_val(cr)
	);

	etq_qmul u_qmul (
		.clk(clk), .en(en[SQ0-1:QM0]),
		.sp(sp), .cp(cp), .sy(sy), .cy(cy), .sr(sr), .cr(cr),
		.qc(qc_mul), .ss(ss)
	);

	etq_sqrt u_sqrt (
		.clk(clk), .en(en[DV0-1:SQ0]), .ss(ss), .qc_in(qc_mul),
		.len(len), .qc_out(qc_root)
	);

	etq_div u_div (
		.clk(clk), .en(en[NS-1:DV0]), .len(len), .qc(qc_root), .quat(quat)
	);

	assign m_tvalid = vld_q[NS-1];
	assign m_tdata = quat;

	`ETQ_ASSERT_NXT(a_accept_enters, clk, arst_n, s_tvalid && s_tready, vld_q[0])
	`ETQ_ASSERT_IMP(a_full_stall, clk, arst_n, (&vld_q) && !m_tready, !s_tready)
	`ETQ_ASSERT_IMP(a_nonzero_out, clk, arst_n, m_tvalid, m_tdata != 64'd0)
	`ETQ_ASSERT_IMP(a_w_range, clk, arst_n, m_tvalid, (m_tdata[63:48] + 16'd16384) <= 16'd32768)

endmodule
`default_nettype wire
